FILE: rtl/line_pixel_generator_unit_defines.svh
// Assertion macros for the line pixel generator.
// Uses the clock and reset signals of the including module; no other dependencies.
`ifndef LINE_PIXEL_GENERATOR_UNIT_DEFINES_SVH
`define LINE_PIXEL_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LPG_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LPG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lpg_pkg.sv
// Shared types and constants for the line pixel generator.
// No dependencies; used by lpg_seq, lpg_div and the top level.
package lpg_pkg;

   localparam int COLOR_BITS = 8;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef enum logic [1:0] {
      KIND_VERT = 2'd0,
      KIND_HORZ = 2'd1,
      KIND_XMAJ = 2'd2,
      KIND_YMAJ = 2'd3
   } line_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_C1,
      ST_MUL_C2,
      ST_MUL_KT,
      ST_ABS,
      ST_DIV,
      ST_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      MUL_MA_NB,
      MUL_NA_MB,
      MUL_K_T
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_SUB,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        div_init;
      logic        div_step;
   } dp_ctrl_type;

endpackage

FILE: rtl/lpg_seq.sv
// Sequencer for the minor coordinate: multiply-accumulate states for each
// product, a sign/magnitude state, COORD_BITS divide steps. Uses lpg_pkg.
module lpg_seq #(
   parameter int COORD_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                minor_calc,
   input  logic                out_free,
   output lpg_pkg::dp_ctrl_type ctrl,
   output logic                idle,
   output logic                done_fire
);

   localparam int CNT_W = $clog2(COORD_BITS);

   lpg_pkg::seq_state_type state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpg_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpg_pkg::ST_IDLE: begin
            if (start) begin
               state_in = minor_calc ? lpg_pkg::ST_MUL_C1 : lpg_pkg::ST_DONE;
            end
         end
         lpg_pkg::ST_MUL_C1: state_in = lpg_pkg::ST_MUL_C2;
         lpg_pkg::ST_MUL_C2: state_in = lpg_pkg::ST_MUL_KT;
         lpg_pkg::ST_MUL_KT: state_in = lpg_pkg::ST_ABS;
         lpg_pkg::ST_ABS:    state_in = lpg_pkg::ST_DIV;
         lpg_pkg::ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = lpg_pkg::ST_DONE;
            end
         end
         lpg_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = lpg_pkg::ST_IDLE;
            end
         end
         default: state_in = lpg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      case (state_ff)
         lpg_pkg::ST_ABS: cnt_in = CNT_W'(COORD_BITS - 1);
         lpg_pkg::ST_DIV: cnt_in = cnt_ff - 1'b1;
         default:         cnt_in = cnt_ff;
      endcase
   end

   always_comb begin
      ctrl.mul_sel  = lpg_pkg::MUL_K_T;
      ctrl.acc_op   = lpg_pkg::ACC_HOLD;
      ctrl.div_init = 1'b0;
      ctrl.div_step = 1'b0;
      idle          = 1'b0;
      done_fire     = 1'b0;
      case (state_ff)
         lpg_pkg::ST_IDLE: idle = 1'b1;
         lpg_pkg::ST_MUL_C1: begin
            ctrl.mul_sel = lpg_pkg::MUL_MA_NB;
            ctrl.acc_op  = lpg_pkg::ACC_LOAD;
         end
         lpg_pkg::ST_MUL_C2: begin
            ctrl.mul_sel = lpg_pkg::MUL_NA_MB;
            ctrl.acc_op  = lpg_pkg::ACC_SUB;
         end
         lpg_pkg::ST_MUL_KT: begin
            ctrl.mul_sel = lpg_pkg::MUL_K_T;
            ctrl.acc_op  = lpg_pkg::ACC_ADD;
         end
         lpg_pkg::ST_ABS:  ctrl.div_init = 1'b1;
         lpg_pkg::ST_DIV:  ctrl.div_step = 1'b1;
         lpg_pkg::ST_DONE: done_fire = out_free;
         default:          idle = 1'b0;
      endcase
   end

endmodule

FILE: rtl/lpg_div.sv
// Arithmetic unit: one signed multiplier feeding an accumulator for the line
// equation numerator, then a restoring shift-subtract divider. Uses lpg_pkg.
module lpg_div #(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  lpg_pkg::dp_ctrl_type  ctrl,
   input  logic [COORD_BITS-1:0] maj_a,
   input  logic [COORD_BITS-1:0] maj_b,
   input  logic [COORD_BITS-1:0] min_a,
   input  logic [COORD_BITS-1:0] min_b,
   input  logic [COORD_BITS-1:0] t,
   output logic [COORD_BITS-1:0] minor
);

   localparam int CB    = COORD_BITS;
   localparam int OPW   = CB + 1;
   localparam int ACC_W = 2 * CB + 2;

   logic signed [OPW-1:0]   k, d, op_a, op_b;
   logic signed [ACC_W-1:0] prod;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0]        num_mag;
   logic [OPW-1:0]          d_abs;
   logic [CB-1:0]           d_mag;
   logic [CB-1:0]           rem_ff, rem_in, quo_ff, quo_in;
   logic                    neg_ff, neg_in;
   logic [CB:0]             trial, diff;
   logic                    fits;

   // numerator = k*t + (ma*nb - na*mb), divisor = ma - mb
   assign k = $signed({1'b0, min_a}) - $signed({1'b0, min_b});
   assign d = $signed({1'b0, maj_a}) - $signed({1'b0, maj_b});

   always_comb begin
      case (ctrl.mul_sel)
         lpg_pkg::MUL_MA_NB: begin
            op_a = $signed({1'b0, maj_a});
            op_b = $signed({1'b0, min_b});
         end
         lpg_pkg::MUL_NA_MB: begin
            op_a = $signed({1'b0, min_a});
            op_b = $signed({1'b0, maj_b});
         end
         default: begin
            op_a = k;
            op_b = $signed({1'b0, t});
         end
      endcase
   end

   assign prod = ACC_W'(op_a) * ACC_W'(op_b);

   always_comb begin
      case (ctrl.acc_op)
         lpg_pkg::ACC_LOAD: acc_in = prod;
         lpg_pkg::ACC_SUB:  acc_in = acc_ff - prod;
         lpg_pkg::ACC_ADD:  acc_in = acc_ff + prod;
         default:           acc_in = acc_ff;
      endcase
   end

   assign num_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign d_abs   = d[CB] ? OPW'(-d) : OPW'(d);
   assign d_mag   = d_abs[CB-1:0];

   // the line value lies between the minor endpoints, so the quotient fits
   // in CB bits and the upper half of the magnitude is already below d_mag
   assign trial = {rem_ff, quo_ff[CB-1]};
   assign fits  = trial >= {1'b0, d_mag};
   assign diff  = trial - {1'b0, d_mag};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      neg_in = neg_ff;
      if (ctrl.div_init) begin
         rem_in = num_mag[2*CB-1:CB];
         quo_in = num_mag[CB-1:0];
         neg_in = acc_ff[ACC_W-1] ^ d[CB];
      end else if (ctrl.div_step) begin
         rem_in = fits ? diff[CB-1:0] : trial[CB-1:0];
         quo_in = {quo_ff[CB-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   // truncation toward zero: divide magnitudes, then restore the sign
   assign minor = neg_ff ? CB'(-quo_ff) : quo_ff;

endmodule

FILE: rtl/line_pixel_generator_unit.sv
// Line pixel generator top level: line state, stream handshakes, result register.
// Depends on lpg_pkg, lpg_seq, lpg_div and line_pixel_generator_unit_defines.svh.
//
//   channel   dir  handshake             payload
//   req       in   req_tvalid/tready     tdata: endpoints and color, tuser: cmd
//   rsp       out  rsp_tvalid/tready     tdata: pixel and color, tlast: last pixel
//
// A load sets the line state directly. A step on a vertical or horizontal line
// goes from idle straight to the sequencer's final state; a diagonal line first
// runs the multiply-accumulate states, the sign/magnitude state and one divide
// step per quotient bit in lpg_div. A step with no line gives no result. Reset
// is synchronous and clears the active-line and result-valid flags. The sequencer
// holds in its final state only while the previous result is stalled.
`include "line_pixel_generator_unit_defines.svh"

module line_pixel_generator_unit #(
   parameter int COORD_BITS = 12,
   localparam int REQ_W = ((4 * COORD_BITS + 3 * lpg_pkg::COLOR_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((2 * COORD_BITS + 3 * lpg_pkg::COLOR_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // x_a, y_a, x_b, y_b, color_r, color_g, color_b, zero pad
   input  logic [REQ_W-1:0] req_tdata,
   // cmd
   input  logic             req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // px, py, out_r, out_g, out_b, zero pad
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);

   localparam int CB  = COORD_BITS;
   localparam int CLR = lpg_pkg::COLOR_BITS;

   logic [CB-1:0]  ax, ay, bx, by, adx, ady;
   logic [CLR-1:0] cr, cg, cb;
   logic           req_xfer, load, start, out_free, idle, done_fire, minor_calc;

   logic                  active_ff, active_in;
   lpg_pkg::line_kind_type kind_ff, kind_in;
   logic [CB-1:0]         pos_ff, pos_in, end_ff, end_in;
   logic [CB-1:0]         xa_ff, xa_in, ya_ff, ya_in, xb_ff, xb_in, yb_ff, yb_in;
   logic [CLR-1:0]        r_ff, r_in, g_ff, g_in, b_ff, b_in;

   logic                  rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [CB-1:0]         rsp_px_ff, rsp_px_in, rsp_py_ff, rsp_py_in;
   logic [CLR-1:0]        rsp_r_ff, rsp_r_in, rsp_g_ff, rsp_g_in, rsp_b_ff, rsp_b_in;

   logic [CB-1:0]         maj_a, maj_b, min_a, min_b, minor, min_lo, min_hi;
   logic [CB-1:0]         px_calc, py_calc;
   logic                  last_calc;
   lpg_pkg::dp_ctrl_type  ctrl;

   assign ax = req_tdata[CB-1:0];
   assign ay = req_tdata[2*CB-1:CB];
   assign bx = req_tdata[3*CB-1:2*CB];
   assign by = req_tdata[4*CB-1:3*CB];
   assign cr = req_tdata[4*CB+CLR-1:4*CB];
   assign cg = req_tdata[4*CB+2*CLR-1:4*CB+CLR];
   assign cb = req_tdata[4*CB+3*CLR-1:4*CB+2*CLR];

   assign adx = (ax > bx) ? ax - bx : bx - ax;
   assign ady = (ay > by) ? ay - by : by - ay;

   assign req_tready = idle;
   assign req_xfer   = req_tvalid && req_tready;
   assign load       = req_xfer && (req_tuser == lpg_pkg::CMD_LOAD);
   assign start      = req_xfer && (req_tuser == lpg_pkg::CMD_STEP) && active_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign minor_calc = (kind_ff == lpg_pkg::KIND_XMAJ) || (kind_ff == lpg_pkg::KIND_YMAJ);

   // x-major divides along x; everything else routed through as y-major
   assign maj_a = (kind_ff == lpg_pkg::KIND_XMAJ) ? xa_ff : ya_ff;
   assign maj_b = (kind_ff == lpg_pkg::KIND_XMAJ) ? xb_ff : yb_ff;
   assign min_a = (kind_ff == lpg_pkg::KIND_XMAJ) ? ya_ff : xa_ff;
   assign min_b = (kind_ff == lpg_pkg::KIND_XMAJ) ? yb_ff : xb_ff;
   assign min_lo = (min_a < min_b) ? min_a : min_b;
   assign min_hi = (min_a < min_b) ? min_b : min_a;

   lpg_seq #(
      .COORD_BITS(CB)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .minor_calc(minor_calc),
      .out_free  (out_free),
      .ctrl      (ctrl),
      .idle      (idle),
      .done_fire (done_fire)
   );

   lpg_div #(
      .COORD_BITS(CB)
   ) u_div (
      .clock(clock),
      .ctrl (ctrl),
      .maj_a(maj_a),
      .maj_b(maj_b),
      .min_a(min_a),
      .min_b(min_b),
      .t    (pos_ff),
      .minor(minor)
   );

   always_comb begin
      case (kind_ff)
         lpg_pkg::KIND_VERT: begin
            px_calc = xa_ff;
            py_calc = pos_ff;
         end
         lpg_pkg::KIND_HORZ: begin
            px_calc = pos_ff;
            py_calc = ya_ff;
         end
         lpg_pkg::KIND_XMAJ: begin
            px_calc = pos_ff;
            py_calc = minor;
         end
         default: begin
            px_calc = minor;
            py_calc = pos_ff;
         end
      endcase
   end

   assign last_calc = pos_ff >= end_ff;

   // line state
   always_comb begin
      active_in = active_ff;
      kind_in   = kind_ff;
      pos_in    = pos_ff;
      end_in    = end_ff;
      xa_in     = xa_ff;
      ya_in     = ya_ff;
      xb_in     = xb_ff;
      yb_in     = yb_ff;
      r_in      = r_ff;
      g_in      = g_ff;
      b_in      = b_ff;
      if (load) begin
         active_in = 1'b1;
         xa_in     = ax;
         ya_in     = ay;
         xb_in     = bx;
         yb_in     = by;
         r_in      = cr;
         g_in      = cg;
         b_in      = cb;
         if (ax == bx) begin
            kind_in = lpg_pkg::KIND_VERT;
         end else if (ay == by) begin
            kind_in = lpg_pkg::KIND_HORZ;
         end else if (adx > ady) begin
            kind_in = lpg_pkg::KIND_XMAJ;
         end else begin
            kind_in = lpg_pkg::KIND_YMAJ;
         end
         // coincident endpoints fall into vertical and step along y
         if ((ax != bx) && ((ay == by) || (adx > ady))) begin
            pos_in = (ax < bx) ? ax : bx;
            end_in = (ax < bx) ? bx : ax;
         end else begin
            pos_in = (ay < by) ? ay : by;
            end_in = (ay < by) ? by : ay;
         end
      end else if (done_fire) begin
         if (last_calc) begin
            active_in = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_px_in    = rsp_px_ff;
      rsp_py_in    = rsp_py_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_g_in     = rsp_g_ff;
      rsp_b_in     = rsp_b_ff;
      if (done_fire) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = last_calc;
         rsp_px_in    = px_calc;
         rsp_py_in    = py_calc;
         rsp_r_in     = r_ff;
         rsp_g_in     = g_ff;
         rsp_b_in     = b_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      pos_ff      <= pos_in;
      end_ff      <= end_in;
      xa_ff       <= xa_in;
      ya_ff       <= ya_in;
      xb_ff       <= xb_in;
      yb_ff       <= yb_in;
      r_ff        <= r_in;
      g_ff        <= g_in;
      b_ff        <= b_in;
      rsp_last_ff <= rsp_last_in;
      rsp_px_ff   <= rsp_px_in;
      rsp_py_ff   <= rsp_py_in;
      rsp_r_ff    <= rsp_r_in;
      rsp_g_ff    <= rsp_g_in;
      rsp_b_ff    <= rsp_b_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_W'({rsp_b_ff, rsp_g_ff, rsp_r_ff, rsp_py_ff, rsp_px_ff});

   `LPG_ASSERT_IMPL(a_busy_has_line, !req_tready, active_ff, "busy without an active line")
   `LPG_ASSERT_IMPL(a_pos_in_range, active_ff, pos_ff <= end_ff, "step position past line end")
   `LPG_ASSERT_NEXT(a_last_ends_line, done_fire && last_calc, !active_ff, "line still active after last pixel")
   `LPG_ASSERT_IMPL(a_minor_in_span, done_fire && minor_calc, (minor >= min_lo) && (minor <= min_hi), "minor coordinate outside endpoint span")

endmodule

FILE: tb/line_pixel_generator_checker.sv
// Pixel scoreboard for the line pixel generator: tracks the latched line from each
// request transfer, predicts every pixel, and compares it with the result stream.
// Depends on lpg_pkg for command codes and line kinds.
module line_pixel_generator_checker #(
   parameter int COORD_BITS = 12,
   localparam int REQ_W = ((4 * COORD_BITS + 3 * lpg_pkg::COLOR_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((2 * COORD_BITS + 3 * lpg_pkg::COLOR_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   // x_a, y_a, x_b, y_b, color_r, color_g, color_b, zero pad
   input  logic [REQ_W-1:0] req_tdata,
   // cmd
   input  logic             req_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   // px, py, out_r, out_g, out_b, zero pad
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic             rsp_tlast,
   output int               fail_count,
   output int               pending_count,
   output int               pixel_count,
   output int               line_count
);

   localparam int C = COORD_BITS;

   typedef struct packed {
      logic [C-1:0] px;
      logic [C-1:0] py;
      logic [7:0]   r;
      logic [7:0]   g;
      logic [7:0]   b;
      logic         last;
   } pixel_type;

   // shadow copy of the line being drawn
   logic                   line_on;
   lpg_pkg::line_kind_type kind;
   logic [C-1:0]           step_at, step_stop;
   logic [C-1:0]           end_xa, end_ya, end_xb, end_yb;
   logic [7:0]             hue_r, hue_g, hue_b;

   pixel_type     pixel_q[$];
   int            fails, pixels, ends;

   // exact (k*t + c) / d, truncated toward zero
   function automatic logic [C-1:0] line_equation(longint k, longint c, longint d,
                                                  longint t);
      longint q;
      if (d == 0) return '0;
      q = (k * t + c) / d;
      return q[C-1:0];
   endfunction

   task automatic advance_line(input logic cmd, input logic [REQ_W-1:0] data);
      logic [C-1:0] ax, ay, bx, by, adx, ady;
      longint       xa, ya, xb, yb;
      pixel_type    p;
      if (cmd == lpg_pkg::CMD_LOAD) begin
         ax = data[C-1:0];
         ay = data[2*C-1:C];
         bx = data[3*C-1:2*C];
         by = data[4*C-1:3*C];
         adx = ax > bx ? ax - bx : bx - ax;
         ady = ay > by ? ay - by : by - ay;
         end_xa = ax;
         end_ya = ay;
         end_xb = bx;
         end_yb = by;
         hue_r = data[4*C+7:4*C];
         hue_g = data[4*C+15:4*C+8];
         hue_b = data[4*C+23:4*C+16];
         if (ax == bx) begin
            kind = lpg_pkg::KIND_VERT;
            step_at = ay < by ? ay : by;
            step_stop = ay < by ? by : ay;
         end else if (ay == by) begin
            kind = lpg_pkg::KIND_HORZ;
            step_at = ax < bx ? ax : bx;
            step_stop = ax < bx ? bx : ax;
         end else if (adx > ady) begin
            kind = lpg_pkg::KIND_XMAJ;
            step_at = ax < bx ? ax : bx;
            step_stop = ax < bx ? bx : ax;
         end else begin
            kind = lpg_pkg::KIND_YMAJ;
            step_at = ay < by ? ay : by;
            step_stop = ay < by ? by : ay;
         end
         line_on = 1'b1;
         return;
      end
      if (!line_on) return;
      xa = end_xa;
      ya = end_ya;
      xb = end_xb;
      yb = end_yb;
      case (kind)
         lpg_pkg::KIND_VERT: begin
            p.px = end_xa;
            p.py = step_at;
         end
         lpg_pkg::KIND_HORZ: begin
            p.px = step_at;
            p.py = end_ya;
         end
         lpg_pkg::KIND_XMAJ: begin
            p.px = step_at;
            p.py = line_equation(ya - yb, xa * yb - ya * xb, xa - xb, step_at);
         end
         default: begin
            p.py = step_at;
            p.px = line_equation(xa - xb, ya * xb - xa * yb, ya - yb, step_at);
         end
      endcase
      p.r = hue_r;
      p.g = hue_g;
      p.b = hue_b;
      p.last = step_at >= step_stop;
      pixel_q.push_back(p);
      if (p.last) line_on = 1'b0;
      else step_at = step_at + 1'b1;
   endtask

   initial begin
      fails = 0;
      pixels = 0;
      ends = 0;
   end

   always @(posedge clock) begin : watch
      pixel_type seen, want;
      if (reset) begin
         line_on = 1'b0;
         kind = lpg_pkg::KIND_VERT;
         step_at = '0;
         step_stop = '0;
         end_xa = '0;
         end_ya = '0;
         end_xb = '0;
         end_yb = '0;
         hue_r = '0;
         hue_g = '0;
         hue_b = '0;
         pixel_q.delete();
      end else begin
         // request first: a result never leaves in the cycle its step is taken
         if (req_tvalid && req_tready) advance_line(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            seen.px = rsp_tdata[C-1:0];
            seen.py = rsp_tdata[2*C-1:C];
            seen.r = rsp_tdata[2*C+7:2*C];
            seen.g = rsp_tdata[2*C+15:2*C+8];
            seen.b = rsp_tdata[2*C+23:2*C+16];
            seen.last = rsp_tlast;
            pixels++;
            if (seen.last) ends++;
            if (pixel_q.size() == 0) begin
               if (fails < 10)
                  $display("%0t: unrequested pixel px=%0d py=%0d rgb=%02h%02h%02h last=%0b",
                           $realtime, seen.px, seen.py, seen.r, seen.g, seen.b, seen.last);
               fails++;
            end else begin
               want = pixel_q.pop_front();
               if (seen != want) begin
                  if (fails < 10) begin
                     $display("%0t: pixel mismatch, expected px=%0d py=%0d rgb=%02h%02h%02h last=%0b",
                              $realtime, want.px, want.py, want.r, want.g, want.b, want.last);
                     $display("   got px=%0d py=%0d rgb=%02h%02h%02h last=%0b",
                              seen.px, seen.py, seen.r, seen.g, seen.b, seen.last);
                  end
                  fails++;
               end
            end
         end
      end
      fail_count <= fails;
      pending_count <= pixel_q.size();
      pixel_count <= pixels;
      line_count <= ends;
   end

endmodule

FILE: tb/line_pixel_generator_unit_test.sv
// Testbench top for line_pixel_generator_unit: drives load and step transfers with
// random gaps and back-pressure, and reports the verdict from the pixel scoreboard.
// Depends on lpg_pkg, line_pixel_generator_unit and line_pixel_generator_checker.
module line_pixel_generator_unit_test;

   localparam int COORD_BITS = 12;
   localparam int REQ_W = ((4 * COORD_BITS + 3 * lpg_pkg::COLOR_BITS + 7) / 8) * 8;
   localparam int RSP_W = ((2 * COORD_BITS + 3 * lpg_pkg::COLOR_BITS + 7) / 8) * 8;
   localparam int COORD_MAX = (1 << COORD_BITS) - 1;
   localparam int ITEMS = 1200;
   localparam int CALM_TAIL = 150;
   localparam int SETTLE_CYCLES = 50;
   localparam int QUIET_LIMIT = 3000;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   int fail_count, pending_count, pixel_count, line_count;
   int load_total, step_total, useful, quiet_cycles;
   bit idle_enable;

   line_pixel_generator_unit #(.COORD_BITS(COORD_BITS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   line_pixel_generator_checker #(.COORD_BITS(COORD_BITS)) pixel_board (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .pixel_count   (pixel_count),
      .line_count    (line_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // one request transfer, optionally after a burst of idle cycles
   task automatic push_req(input logic cmd, input logic [REQ_W-1:0] data);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (cmd == lpg_pkg::CMD_LOAD) load_total++;
      else step_total++;
   endtask

   task automatic load_line(input int xa, ya, xb, yb, input int r, g, b);
      push_req(lpg_pkg::CMD_LOAD,
               REQ_W'({8'(b), 8'(g), 8'(r), COORD_BITS'(yb), COORD_BITS'(xb),
                       COORD_BITS'(ya), COORD_BITS'(xa)}));
   endtask

   // endpoint and color bits are don't-care on a step; keep them moving
   task automatic step_line();
      push_req(lpg_pkg::CMD_STEP, REQ_W'({$urandom, $urandom, $urandom}));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // line of a random shape, mostly short and usually run to its end
   task automatic random_line();
      int xa, ya, xb, yb, dx, dy, span, steps;
      bit wide;
      xa = $urandom_range(0, COORD_MAX);
      ya = $urandom_range(0, COORD_MAX);
      wide = $urandom_range(0, 11) == 0;
      if (wide) begin
         xb = $urandom_range(0, COORD_MAX);
         yb = $urandom_range(0, COORD_MAX);
      end else begin
         case ($urandom_range(0, 9))
            0: begin
               dx = 0;
               dy = $urandom_range(0, 15);
            end
            1: begin
               dx = $urandom_range(1, 15);
               dy = 0;
            end
            2: begin
               dx = $urandom_range(1, 12);
               dy = dx;
            end
            default: begin
               dx = $urandom_range(0, 15);
               dy = $urandom_range(0, 15);
            end
         endcase
         if ($urandom_range(0, 1)) dx = -dx;
         if ($urandom_range(0, 1)) dy = -dy;
         xb = (xa + dx < 0 || xa + dx > COORD_MAX) ? xa - dx : xa + dx;
         yb = (ya + dy < 0 || ya + dy > COORD_MAX) ? ya - dy : ya + dy;
      end
      dx = xb > xa ? xb - xa : xa - xb;
      dy = yb > ya ? yb - ya : ya - yb;
      span = (dx > dy ? dx : dy) + 1;
      load_line(xa, ya, xb, yb, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255));
      if (wide) steps = $urandom_range(1, 16);
      else case ($urandom_range(0, 9))
         7, 8: steps = span + $urandom_range(1, 3);
         9: steps = $urandom_range(1, span);
         default: steps = span;
      endcase
      repeat (steps) step_line();
      useful += 1 + (steps < span ? steps : span);
   endtask

   // sink back-pressure: ready bursts, stall bursts while idling is allowed
   initial begin : sink_stall
      int n;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         n = $urandom_range(0, 7) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 30);
         repeat (n) @(posedge clock);
         if (idle_enable) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int pause_mark;
      pause_mark = 450;
      load_total = 0;
      step_total = 0;
      useful = 0;
      idle_enable <= 1'b1;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= lpg_pkg::CMD_LOAD;
      req_tdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      step_line();  // nothing latched yet
      load_line(0, 0, 0, 0, 'h00, 'h00, 'h00);  // single point
      repeat (2) step_line();
      load_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 2, 'hff, 'hff, 'hff);
      repeat (3) step_line();
      load_line(COORD_MAX - 2, 0, COORD_MAX, 0, 'h5a, 'ha5, 'h0f);
      repeat (3) step_line();
      // full-span diagonal, cut off by the next load
      load_line(0, COORD_MAX, COORD_MAX, 0, 'hff, 'h00, 'h80);
      repeat (2) step_line();
      load_line(10, 20, 13, 23, 'h01, 'h80, 'hfe);  // equal spans go y-major
      repeat (4) step_line();
      load_line(5, 9, 0, 7, 'h33, 'hcc, 'h77);
      repeat (2) step_line();
      load_line(COORD_MAX, 0, COORD_MAX - 5, COORD_MAX, 'h80, 'h7f, 'h01);
      repeat (2) step_line();

      while (useful < ITEMS) begin
         if ($urandom_range(0, 6) != 0) begin
            random_line();
         end else if ($urandom_range(0, 1)) begin
            step_line();
         end else begin
            load_line($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255));
            useful++;
         end
         if (useful >= pause_mark) begin
            drain_results();
            pause_mark += 450;
         end
         if (useful >= ITEMS - CALM_TAIL) idle_enable <= 1'b0;
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Drove %0d line loads and %0d pixel requests: edge lines, ties, points,",
               load_total, step_total);
      $display("short random lines and cut-off long ones; %0d pixels, %0d line ends seen.",
               pixel_count, line_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lpg_pkg.sv
rtl/lpg_seq.sv
rtl/lpg_div.sv
rtl/line_pixel_generator_unit.sv
tb/line_pixel_generator_checker.sv
tb/line_pixel_generator_unit_test.sv
